[rtl/avr_pkg.sv]
// avr_pkg: shared types, constants and the arctangent table for the vector rotator.
// No dependencies; every rtl file but avr_checker refers to it by scoped names.
package avr_pkg;

  // Degrees in a half turn; the angle reduction and fold are built from it
  localparam int HALF_TURN_DEG = 180;
  // Length of the arctangent table, caps the number of CORDIC iterations
  localparam int TABLE_LEN = 30;
  // CORDIC datapath width (sign + guard over Q1.30 / Q2.30)
  localparam int CW = 33;
  // 1/gain limit in Q1.30
  localparam logic signed [CW-1:0] INV_GAIN_Q30 = 33'sd652032874;
  // pi/180 in Q0.32
  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_PASS = 2'd3
  } axis_t;

  // Request payload as it rides down the pipe, plus the quadrant signs
  typedef struct packed {
    axis_t              op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sneg;
    logic               cneg;
  } item_t;

  // CORDIC working vector and residual angle
  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } result_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      24: v = 32'd63;
      25: v = 32'd31;
      26: v = 32'd15;
      27: v = 32'd7;
      28: v = 32'd3;
      29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/axis_vector_rotator.sv]
// Throughput: one request per cycle while in_ready is high; the pipeline is six angle-prep
// stages, one CORDIC cell per iteration, two multiply/round stages and a registered output.
// A one-entry skid behind the output register holds a result while out_ready is low;
// in_ready falls only when that skid is full.
// Reset (rst, synchronous, active high) empties the pipe; no other state is kept.
module axis_vector_rotator #(
  parameter int FRAC_BITS   = 16,
  parameter int TRIG_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  input  logic signed [31:0] angle_deg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out,
  output logic               saturated
);

  localparam int NST = (TRIG_STAGES > avr_pkg::TABLE_LEN) ? avr_pkg::TABLE_LEN : TRIG_STAGES;

  // Whole pipe advances unless the skid entry is occupied
  logic en;
  logic skid_valid;
  avr_pkg::result_t skid_res;
  avr_pkg::result_t out_res;

  assign en       = !skid_valid;
  assign in_ready = !skid_valid;

  avr_pkg::item_t req_item;

  always_comb begin
    req_item.op   = avr_pkg::axis_t'(op);
    req_item.x    = x_in;
    req_item.y    = y_in;
    req_item.z    = z_in;
    req_item.sneg = 1'b0;
    req_item.cneg = 1'b0;
  end

  // Angle reduction and conversion
  logic                          prep_valid;
  avr_pkg::item_t                prep_item;
  logic signed [avr_pkg::CW-1:0] prep_rad;

  avr_angle_prep #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid & in_ready),
    .in_item  (req_item),
    .in_angle (angle_deg),
    .out_valid(prep_valid),
    .out_item (prep_item),
    .out_rad  (prep_rad)
  );

  // CORDIC chain, one cell per iteration
  logic             c_valid [NST+1];
  avr_pkg::item_t   c_item  [NST+1];
  avr_pkg::cordic_t c_st    [NST+1];

  assign c_valid[0]   = prep_valid;
  assign c_item[0]    = prep_item;
  assign c_st[0].cx   = avr_pkg::INV_GAIN_Q30;
  assign c_st[0].cy   = '0;
  assign c_st[0].cz   = prep_rad;

  for (genvar i = 0; i < NST; i++) begin : g_cell
    avr_cordic_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (c_valid[i]),
      .in_item  (c_item[i]),
      .in_st    (c_st[i]),
      .out_valid(c_valid[i+1]),
      .out_item (c_item[i+1]),
      .out_st   (c_st[i+1])
    );
  end

  // Matrix apply, rounding and saturation
  logic rot_valid;

  avr_rotate u_rot (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_valid[NST]),
    .in_item  (c_item[NST]),
    .in_st    (c_st[NST]),
    .out_valid(rot_valid),
    .out_res  (out_res)
  );

  // Output register with one skid entry
  logic push;
  logic pop;
  avr_pkg::result_t out_reg;

  assign push = en & rot_valid;
  assign pop  = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_reg    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_reg   <= out_res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= out_res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign x_out     = out_reg.x;
  assign y_out     = out_reg.y;
  assign z_out     = out_reg.z;
  assign saturated = out_reg.sat;

endmodule

[rtl/avr_angle_prep.sv]
// avr_angle_prep: reduces the angle modulo a full turn, folds it into the first
// quadrant and converts it to Q2.30 radians. Six register stages. Uses avr_pkg.
module avr_angle_prep #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  avr_pkg::item_t               in_item,
  input  logic signed [31:0]           in_angle,
  output logic                         out_valid,
  output avr_pkg::item_t               out_item,
  output logic signed [avr_pkg::CW-1:0] out_rad
);

  // A full turn is RED_MOD << (FRAC_BITS + 3); the low bits pass straight through
  localparam int RED_MOD = avr_pkg::HALF_TURN_DEG / 4;
  localparam int LW      = FRAC_BITS + 3;
  localparam int REMW    = $clog2(RED_MOD);
  localparam int RW      = REMW + LW;
  localparam int UW      = 22;
  localparam int QW      = 17;
  localparam int RSH     = 28;
  localparam int PW      = UW + 23;
  localparam logic [UW-1:0] U_OFS = UW'(RED_MOD << 15);
  localparam logic [22:0]   RECIP = 23'((2 ** RSH) / RED_MOD);
  localparam logic [RW-1:0] QUARTER = RW'(64'(avr_pkg::HALF_TURN_DEG / 2) << FRAC_BITS);
  localparam logic [RW-1:0] HALF    = RW'(64'(avr_pkg::HALF_TURN_DEG) << FRAC_BITS);
  localparam logic [RW-1:0] THREEQ  = RW'(64'(avr_pkg::HALF_TURN_DEG * 3 / 2) << FRAC_BITS);
  localparam logic [RW-1:0] FULL    = RW'(64'(avr_pkg::HALF_TURN_DEG * 2) << FRAC_BITS);
  // Folded angle width and the split for the radian product
  localparam int MW  = $clog2(avr_pkg::HALF_TURN_DEG / 2 + 1) + FRAC_BITS;
  localparam int ML  = MW / 2;
  localparam int MH  = MW - ML;
  localparam int SW  = MW + 28;
  localparam logic [SW-1:0] RAD_RND = SW'(1) << (FRAC_BITS + 1);

  // Stage 1: turn count in units of 2^(FRAC_BITS+3), offset to positive
  logic signed [63:0] ang64;
  logic signed [63:0] qsh;
  logic [UW-1:0] u1;
  logic [LW-1:0] low1;
  logic          v1;
  avr_pkg::item_t it1;

  assign ang64 = 64'(in_angle);
  assign qsh   = ang64 >>> LW;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      u1   <= qsh[UW-1:0] + U_OFS;
      low1 <= ang64[LW-1:0];
      it1  <= in_item;
    end
  end

  // Stage 2: quotient estimate by reciprocal multiply
  logic [PW-1:0] prod2;
  logic [QW-1:0] q2;
  logic [UW-1:0] u2;
  logic [LW-1:0] low2;
  logic          v2;
  avr_pkg::item_t it2;

  assign prod2 = PW'(u1) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      q2   <= prod2[RSH +: QW];
      u2   <= u1;
      low2 <= low1;
      it2  <= it1;
    end
  end

  // Stage 3: remainder with one correction step, then reassemble
  logic [UW-1:0] qm3;
  logic [UW-1:0] rem3;
  logic [UW-1:0] remc3;
  logic [RW-1:0] r3;
  logic          v3;
  avr_pkg::item_t it3;

  assign qm3   = UW'(q2) * UW'(RED_MOD);
  assign rem3  = u2 - qm3;
  assign remc3 = (rem3 >= UW'(RED_MOD)) ? rem3 - UW'(RED_MOD) : rem3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      r3  <= {remc3[REMW-1:0], low2};
      it3 <= it2;
    end
  end

  // Stage 4: fold into [0, quarter] with quadrant signs
  logic [RW-1:0] mf;
  logic          sn;
  logic          cn;
  logic [MW-1:0] m4;
  logic          v4;
  avr_pkg::item_t it3f;
  avr_pkg::item_t it4;

  always_comb begin
    sn = 1'b0;
    cn = 1'b0;
    if (r3 <= QUARTER) begin
      mf = r3;
    end else if (r3 <= HALF) begin
      mf = HALF - r3;
      cn = 1'b1;
    end else if (r3 <= THREEQ) begin
      mf = r3 - HALF;
      sn = 1'b1;
      cn = 1'b1;
    end else begin
      mf = FULL - r3;
      sn = 1'b1;
    end
  end

  // Quadrant signs ride with the request
  always_comb begin
    it3f      = it3;
    it3f.sneg = sn;
    it3f.cneg = cn;
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      m4  <= mf[MW-1:0];
      it4 <= it3f;
    end
  end

  // Stage 5: degrees to radians, two partial products
  logic [ML+26:0] pl5;
  logic [MH+26:0] ph5;
  logic           v5;
  avr_pkg::item_t it5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      pl5 <= (ML+27)'(m4[ML-1:0]) * (ML+27)'(avr_pkg::DEG_TO_RAD_Q32);
      ph5 <= (MH+27)'(m4[MW-1:ML]) * (MH+27)'(avr_pkg::DEG_TO_RAD_Q32);
      it5 <= it4;
    end
  end

  // Stage 6: combine, round and scale to Q2.30
  logic [SW-1:0] sum6;
  logic [SW-1:0] sh6;

  assign sum6 = (SW'(ph5) << ML) + SW'(pl5) + RAD_RND;
  assign sh6  = sum6 >> (FRAC_BITS + 2);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v5;
    if (en) begin
      out_rad  <= $signed(sh6[avr_pkg::CW-1:0]);
      out_item <= it5;
    end
  end

endmodule

[rtl/avr_cordic_cell.sv]
// avr_cordic_cell: one CORDIC rotation-mode iteration with its own register.
// Uses avr_pkg for the working types and the arctangent table.
module avr_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  avr_pkg::item_t   in_item,
  input  avr_pkg::cordic_t in_st,
  output logic             out_valid,
  output avr_pkg::item_t   out_item,
  output avr_pkg::cordic_t out_st
);

  localparam logic signed [avr_pkg::CW-1:0] ATN =
    $signed({1'b0, avr_pkg::atan_q30(IDX)});

  logic signed [avr_pkg::CW-1:0] cx;
  logic signed [avr_pkg::CW-1:0] cy;
  logic signed [avr_pkg::CW-1:0] cz;
  logic signed [avr_pkg::CW-1:0] xs;
  logic signed [avr_pkg::CW-1:0] ys;
  avr_pkg::cordic_t st_next;

  assign cx = in_st.cx;
  assign cy = in_st.cy;
  assign cz = in_st.cz;
  assign xs = cx >>> IDX;
  assign ys = cy >>> IDX;

  // Rotate toward zero residual angle
  always_comb begin
    if (!cz[avr_pkg::CW-1]) begin
      st_next.cx = cx - ys;
      st_next.cy = cy + xs;
      st_next.cz = cz - ATN;
    end else begin
      st_next.cx = cx + ys;
      st_next.cy = cy - xs;
      st_next.cz = cz + ATN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
    if (en) begin
      out_st   <= st_next;
      out_item <= in_item;
    end
  end

endmodule

[rtl/avr_rotate.sv]
// avr_rotate: applies quadrant signs to sine/cosine, multiplies by the selected
// components, rounds to Q16.16 and saturates. Uses avr_pkg.
module avr_rotate (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  avr_pkg::item_t    in_item,
  input  avr_pkg::cordic_t  in_st,
  output logic              out_valid,
  output avr_pkg::result_t  out_res
);

  localparam logic signed [avr_pkg::CW-1:0] ONE_Q30 = 33'sd1073741824;
  localparam logic signed [63:0] RND = 64'sd536870912;

  // Stage 1: clip, sign by quadrant, pick operands by axis
  logic signed [avr_pkg::CW-1:0] cxc;
  logic signed [avr_pkg::CW-1:0] cyc;
  logic signed [31:0] cv;
  logic signed [31:0] sv;
  logic signed [31:0] a_sel;
  logic signed [31:0] b_sel;
  logic signed [31:0] s_sel;
  logic signed [31:0] a1;
  logic signed [31:0] b1;
  logic signed [31:0] c1;
  logic signed [31:0] s1;
  logic               v1;
  avr_pkg::item_t     it1;

  always_comb begin
    cxc = in_st.cx;
    if (in_st.cx > ONE_Q30) cxc = ONE_Q30;
    else if (in_st.cx < -ONE_Q30) cxc = -ONE_Q30;
    cyc = in_st.cy;
    if (in_st.cy > ONE_Q30) cyc = ONE_Q30;
    else if (in_st.cy < -ONE_Q30) cyc = -ONE_Q30;
    cv = in_item.cneg ? -cxc[31:0] : cxc[31:0];
    sv = in_item.sneg ? -cyc[31:0] : cyc[31:0];
  end

  // Y uses the transposed rows: same form with the sine negated
  always_comb begin
    s_sel = sv;
    case (in_item.op)
      avr_pkg::AXIS_X: begin
        a_sel = in_item.y;
        b_sel = in_item.z;
      end
      avr_pkg::AXIS_Y: begin
        a_sel = in_item.x;
        b_sel = in_item.z;
        s_sel = -sv;
      end
      default: begin
        a_sel = in_item.x;
        b_sel = in_item.y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      a1  <= a_sel;
      b1  <= b_sel;
      c1  <= cv;
      s1  <= s_sel;
      it1 <= in_item;
    end
  end

  // Stage 2: four products in Q16.46
  logic signed [63:0] pac;
  logic signed [63:0] pbs;
  logic signed [63:0] pas;
  logic signed [63:0] pbc;
  avr_pkg::item_t     it2;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v1;
    if (en) begin
      pac <= 64'(a1) * 64'(c1);
      pbs <= 64'(b1) * 64'(s1);
      pas <= 64'(a1) * 64'(s1);
      pbc <= 64'(b1) * 64'(c1);
      it2 <= it1;
    end
  end

  // Round to Q16.16 and clip to 32 bits
  logic signed [63:0] sum1;
  logic signed [63:0] sum2;
  logic signed [63:0] sh1;
  logic signed [63:0] sh2;
  logic signed [31:0] r1;
  logic signed [31:0] r2;
  logic               sat1;
  logic               sat2;

  assign sum1 = pac + pbs + RND;
  assign sum2 = pbc - pas + RND;
  assign sh1  = sum1 >>> 30;
  assign sh2  = sum2 >>> 30;
  assign sat1 = (sh1[33:31] != 3'b000) && (sh1[33:31] != 3'b111);
  assign sat2 = (sh2[33:31] != 3'b000) && (sh2[33:31] != 3'b111);
  assign r1   = sat1 ? (sh1[33] ? 32'sh80000000 : 32'sh7fffffff) : sh1[31:0];
  assign r2   = sat2 ? (sh2[33] ? 32'sh80000000 : 32'sh7fffffff) : sh2[31:0];

  // Place the two rotated components by axis
  always_comb begin
    out_res.x   = it2.x;
    out_res.y   = it2.y;
    out_res.z   = it2.z;
    out_res.sat = sat1 | sat2;
    case (it2.op)
      avr_pkg::AXIS_X: begin
        out_res.y = r1;
        out_res.z = r2;
      end
      avr_pkg::AXIS_Y: begin
        out_res.x = r1;
        out_res.z = r2;
      end
      avr_pkg::AXIS_Z: begin
        out_res.x = r1;
        out_res.y = r2;
      end
      default: begin
        out_res.sat = 1'b0;
      end
    endcase
  end

endmodule

[rtl/avr_checker.sv]
// avr_checker: port-level checks on the vector rotator, attached by bind.
// Sees only the top-level ports; no package dependency.
module avr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] x_out,
  input logic signed [31:0] y_out,
  input logic signed [31:0] z_out,
  input logic               saturated
);

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out) &&
    $stable(z_out) && $stable(saturated))
    else $error("result changed while stalled");

  // Backpressure only while a result is waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with no pending result");

  // Ready returns only after a result is taken
  a_ready_release: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) && !$past(rst) |-> $past(out_valid && out_ready))
    else $error("in_ready rose without a result taken");

  // Saturation shows a clipped component
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> x_out == SMAX || x_out == SMIN || y_out == SMAX ||
    y_out == SMIN || z_out == SMAX || z_out == SMIN)
    else $error("saturated without a component at a rail");

endmodule

bind axis_vector_rotator avr_checker u_avr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .x_out    (x_out),
  .y_out    (y_out),
  .z_out    (z_out),
  .saturated(saturated)
);
